[hdl/tlsa_pkg.sv]
// ----------------------------------------------------------------------------
// tlsa_pkg
// Shared constants, codes and controller/datapath interface types for the
// thread-local slot allocator.
// ----------------------------------------------------------------------------
package tlsa_pkg;

    localparam int ADDR_W      = 48;
    localparam int MAX_PAGES   = 16;
    localparam int PAGE_IDX_W  = 4;
    localparam int PAGE_CNT_W  = 5;
    localparam int SLOTS       = 8;
    localparam int SLOT_IDX_W  = 3;
    localparam int SLOT_SHIFT  = 9;
    localparam int PAGE_SHIFT  = 12;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 64;

    localparam logic [SLOTS-1:0] FULL_MAP = '1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_PAGE  = 2'd1,
        ST_BAD_FREE = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef struct packed {
        logic capture;
        logic step;
        logic do_free;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_room;
    } t_sts;

    function automatic logic [SLOT_IDX_W-1:0] first_free(input logic [SLOTS-1:0] map);
        logic [SLOT_IDX_W-1:0] idx;
        idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!map[s]) begin
                idx = SLOT_IDX_W'(s);
            end
        end
        return idx;
    endfunction

endpackage

[hdl/thread_local_slot_allocator_top.sv]
// ----------------------------------------------------------------------------
// thread_local_slot_allocator_top
// Bitmap slot allocator: eight 512-byte slots per 4 KiB page, up to 16 pages.
// ----------------------------------------------------------------------------
// One item at a time. An allocate scans the opened pages one per cycle in the
// datapath's scan loop, up to the first non-full page, or up to the end of the
// open pages when a page must be opened or none is left; its result is then
// handed to the output register once that has room. A free decodes its address
// in its own state before its result is handed on in the same way.
// A new item is accepted while the previous result still waits in the output
// register. region_base sits at APB byte address 0 (64-bit data, low 48 bits
// used); write it only while the block is idle.
module thread_local_slot_allocator_top
    import tlsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_action,
    input  logic [ADDR_W-1:0]  i_slot_address_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [ADDR_W-1:0]  o_slot_address,
    output logic               o_new_page,
    output logic [1:0]         o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [ADDR_W-1:0] w_region_base;
    t_cmd              w_cmd;
    t_sts              w_sts;

    tlsa_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_region_base (w_region_base)
    );

    tlsa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_ready  (o_ready),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd)
    );

    tlsa_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_region_base     (w_region_base),
        .i_slot_address_in (i_slot_address_in),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_slot_address    (o_slot_address),
        .o_new_page        (o_new_page),
        .o_status          (o_status)
    );

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("item accepted while another is in flight");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> ((o_slot_address == '0) && !o_new_page))
        else $error("error result carries an address or new page flag");

    a_new_page_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_new_page) |-> (o_status == ST_OK))
        else $error("new page flagged on a failed item");

endmodule

[hdl/tlsa_regs.sv]
// ----------------------------------------------------------------------------
// tlsa_regs
// APB register file holding the region base address.
// ----------------------------------------------------------------------------
module tlsa_regs
    import tlsa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [ADDR_W-1:0]  o_region_base
);

    logic [ADDR_W-1:0] r_base;
    logic              w_sel_base;

    assign w_sel_base = (paddr[PADDR_W-1] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (psel && penable && pwrite && w_sel_base) begin
            r_base <= pwdata[ADDR_W-1:0];
        end
    end

    assign prdata        = w_sel_base ? {{(PDATA_W-ADDR_W){1'b0}}, r_base} : '0;
    assign pready        = 1'b1;
    assign o_region_base = r_base;

endmodule

[hdl/tlsa_ctrl.sv]
// ----------------------------------------------------------------------------
// tlsa_ctrl
// Sequencer: accepts an item, runs the page scan or the free, then hands the
// result to the output register.
// ----------------------------------------------------------------------------
module tlsa_ctrl
    import tlsa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_action,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FREE = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_action == ACT_FREE) ? S_FREE : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_FREE: begin
                o_cmd.do_free = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_room) begin
                    o_cmd.push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/tlsa_dp.sv]
// ----------------------------------------------------------------------------
// tlsa_dp
// Datapath: occupancy maps, open page count, page scan, free decode and the
// output register.
// ----------------------------------------------------------------------------
module tlsa_dp
    import tlsa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [ADDR_W-1:0] i_region_base,
    input  logic [ADDR_W-1:0] i_slot_address_in,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADDR_W-1:0] o_slot_address,
    output logic              o_new_page,
    output logic [1:0]        o_status
);

    logic [SLOTS-1:0]      r_occ [MAX_PAGES];
    logic [PAGE_CNT_W-1:0] r_pages_open;
    logic [PAGE_CNT_W-1:0] r_scan;
    logic [ADDR_W-1:0]     r_addr_in;
    logic [ADDR_W-1:0]     r_res_addr;
    logic                  r_res_new;
    t_status               r_res_status;
    logic                  r_out_valid;
    logic [ADDR_W-1:0]     r_out_addr;
    logic                  r_out_new;
    t_status               r_out_status;

    logic [PAGE_IDX_W-1:0] w_idx;
    logic [SLOTS-1:0]      w_map;
    logic                  w_in_open;
    logic                  w_hit;
    logic                  w_end;
    logic                  w_exhaust;
    logic [SLOT_IDX_W-1:0] w_slot;
    logic [PAGE_IDX_W-1:0] w_new_idx;
    logic [ADDR_W-1:0]     w_hit_addr;
    logic [ADDR_W-1:0]     w_new_addr;
    logic [ADDR_W-1:0]     w_offset;
    logic                  w_free_ok;
    logic [PAGE_IDX_W-1:0] w_free_page;
    logic [SLOT_IDX_W-1:0] w_free_slot;

    assign w_idx      = r_scan[PAGE_IDX_W-1:0];
    assign w_map      = r_occ[w_idx];
    assign w_in_open  = (r_scan < r_pages_open);
    assign w_hit      = w_in_open && (w_map != FULL_MAP);
    assign w_end      = !w_in_open;
    assign w_exhaust  = (r_pages_open == PAGE_CNT_W'(MAX_PAGES));
    assign w_slot     = first_free(w_map);
    assign w_new_idx  = r_pages_open[PAGE_IDX_W-1:0];
    assign w_hit_addr = i_region_base
                      + {{(ADDR_W-PAGE_IDX_W-PAGE_SHIFT){1'b0}}, w_idx, w_slot,
                         {SLOT_SHIFT{1'b0}}};
    assign w_new_addr = i_region_base
                      + {{(ADDR_W-PAGE_IDX_W-PAGE_SHIFT){1'b0}}, w_new_idx,
                         {PAGE_SHIFT{1'b0}}};

    assign w_offset    = r_addr_in - i_region_base;
    assign w_free_ok   = (w_offset[ADDR_W-1:PAGE_SHIFT]
                          < {{(ADDR_W-PAGE_SHIFT-PAGE_CNT_W){1'b0}}, r_pages_open});
    assign w_free_page = w_offset[PAGE_SHIFT+PAGE_IDX_W-1:PAGE_SHIFT];
    assign w_free_slot = w_offset[PAGE_SHIFT-1:SLOT_SHIFT];

    assign o_sts.scan_done = w_hit || w_end;
    assign o_sts.out_room  = !r_out_valid || i_ready;

    // occupancy maps, no reset: a page's map is written when the page opens
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_hit) begin
            r_occ[w_idx] <= w_map | (SLOTS'(1) << w_slot);
        end else if (i_cmd.step && w_end && !w_exhaust) begin
            r_occ[w_new_idx] <= SLOTS'(1);
        end else if (i_cmd.do_free && w_free_ok) begin
            r_occ[w_free_page] <= r_occ[w_free_page] & ~(SLOTS'(1) << w_free_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages_open <= '0;
        end else if (i_cmd.step && !w_hit && w_end && !w_exhaust) begin
            r_pages_open <= r_pages_open + PAGE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr_in <= i_slot_address_in;
            r_scan    <= '0;
        end else if (i_cmd.step && !w_hit && !w_end) begin
            r_scan <= r_scan + PAGE_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_hit) begin
            r_res_addr   <= w_hit_addr;
            r_res_new    <= 1'b0;
            r_res_status <= ST_OK;
        end else if (i_cmd.step && w_end) begin
            r_res_addr   <= w_exhaust ? '0 : w_new_addr;
            r_res_new    <= !w_exhaust;
            r_res_status <= w_exhaust ? ST_NO_PAGE : ST_OK;
        end else if (i_cmd.do_free) begin
            r_res_addr   <= '0;
            r_res_new    <= 1'b0;
            r_res_status <= w_free_ok ? ST_OK : ST_BAD_FREE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_addr   <= r_res_addr;
            r_out_new    <= r_res_new;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_slot_address = r_out_addr;
    assign o_new_page     = r_out_new;
    assign o_status       = r_out_status;

endmodule

[dv/slot_alloc_checker.sv]
// ----------------------------------------------------------------------------
// slot_alloc_checker
// Watches the request, result and register channels of the slot allocator,
// tracks page occupancy and the region base on its own, and compares every
// result item field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module slot_alloc_checker
    import tlsa_pkg::*;
#(
    parameter logic [PADDR_W-1:0] BASE_REG_ADDR = '0
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_action,
    input  logic [ADDR_W-1:0]  i_addr_in,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [ADDR_W-1:0]  i_slot_address,
    input  logic               i_new_page,
    input  logic [1:0]         i_status,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int MAX_REPORTS = 200;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              new_page;
        t_status           status;
    } t_slot_result;

    t_slot_result          slot_results[$];
    t_slot_result          want;
    logic [SLOTS-1:0]      occ_map [MAX_PAGES];
    logic [PAGE_CNT_W-1:0] open_pages;
    logic [ADDR_W-1:0]     base;

    function automatic t_slot_result allocate_slot();
        t_slot_result          res;
        logic                  found;
        logic                  hit;
        logic [SLOT_IDX_W-1:0] slot;
        res = '{addr: '0, new_page: 1'b0, status: ST_OK};
        found = 1'b0;
        for (int p = 0; p < MAX_PAGES; p++) begin
            if (!found && p < open_pages && occ_map[p] != FULL_MAP) begin
                hit = 1'b0;
                slot = '0;
                for (int s = 0; s < SLOTS; s++) begin
                    if (!hit && !occ_map[p][s]) begin
                        slot = SLOT_IDX_W'(s);
                        hit = 1'b1;
                    end
                end
                occ_map[p][slot] = 1'b1;
                res.addr = base + (ADDR_W'(p) << PAGE_SHIFT) + (ADDR_W'(slot) << SLOT_SHIFT);
                found = 1'b1;
            end
        end
        if (!found) begin
            if (open_pages >= MAX_PAGES) begin
                res.status = ST_NO_PAGE;
            end else begin
                occ_map[open_pages[PAGE_IDX_W-1:0]] = SLOTS'(1);
                res.addr = base + (ADDR_W'(open_pages) << PAGE_SHIFT);
                res.new_page = 1'b1;
                open_pages = open_pages + 1'b1;
            end
        end
        return res;
    endfunction

    function automatic t_slot_result release_slot(input logic [ADDR_W-1:0] addr_in);
        t_slot_result      res;
        logic [ADDR_W-1:0] offset;
        res = '{addr: '0, new_page: 1'b0, status: ST_OK};
        offset = addr_in - base;
        if (offset[ADDR_W-1:PAGE_SHIFT] >= open_pages) begin
            res.status = ST_BAD_FREE;
        end else begin
            occ_map[offset[PAGE_SHIFT +: PAGE_IDX_W]][offset[SLOT_SHIFT +: SLOT_IDX_W]] = 1'b0;
        end
        return res;
    endfunction

    task automatic note_mismatch(input string what, input logic [ADDR_W-1:0] exp_val,
                                 input logic [ADDR_W-1:0] act_val);
        if (o_fail_count < MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, what, exp_val, act_val);
        end
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            base = '0;
            open_pages = '0;
            foreach (occ_map[i]) begin
                occ_map[i] = '0;
            end
            slot_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == BASE_REG_ADDR) begin
                base = i_pwdata[ADDR_W-1:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (slot_results.size() == 0) begin
                    if (o_fail_count < MAX_REPORTS) begin
                        $display("%0t: unexpected result: expected none actual %h/%b/%0d",
                                 $time, i_slot_address, i_new_page, i_status);
                    end
                    o_fail_count++;
                end else begin
                    want = slot_results.pop_front();
                    if (i_slot_address !== want.addr) begin
                        note_mismatch("slot_address", want.addr, i_slot_address);
                    end
                    if (i_new_page !== want.new_page) begin
                        note_mismatch("new_page", ADDR_W'(want.new_page), ADDR_W'(i_new_page));
                    end
                    if (i_status !== want.status) begin
                        note_mismatch("status", ADDR_W'(want.status), ADDR_W'(i_status));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_action == ACT_FREE) begin
                    slot_results.insert(slot_results.size(), release_slot(i_addr_in));
                end else begin
                    slot_results.insert(slot_results.size(), allocate_slot());
                end
            end
        end
        o_pending = slot_results.size();
    end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the thread-local slot allocator: a directed run through page
// opening, wrap-around, frees inside slots, double and stray frees, then
// random allocate/free mixes under several region bases, with bursty input
// and a stalling receiver. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module tb_top;
    import tlsa_pkg::*;

    localparam logic [PADDR_W-1:0] REGION_BASE_ADDR = PADDR_W'(0);
    localparam logic [ADDR_W-1:0]  TOP_ALIGNED_BASE = 48'hFFFF_FFFF_F000;
    localparam logic [ADDR_W-1:0]  ALL_ONES_ADDR    = '1;
    localparam int                 PHASE_ITEMS      = 266;
    localparam int                 HOLD_CYCLES      = 250;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               in_action;
    logic [ADDR_W-1:0]  in_addr;
    logic               out_valid;
    logic               out_ready;
    logic [ADDR_W-1:0]  out_addr;
    logic               out_new_page;
    logic [1:0]         out_status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;
    int                 burst_left;
    logic [ADDR_W-1:0]  cur_base;

    thread_local_slot_allocator_top i_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_valid           (in_valid),
        .o_ready           (in_ready),
        .i_action          (in_action),
        .i_slot_address_in (in_addr),
        .o_valid           (out_valid),
        .i_ready           (out_ready),
        .o_slot_address    (out_addr),
        .o_new_page        (out_new_page),
        .o_status          (out_status),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    slot_alloc_checker #(
        .BASE_REG_ADDR (REGION_BASE_ADDR)
    ) i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_action       (in_action),
        .i_addr_in      (in_addr),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_slot_address (out_addr),
        .i_new_page     (out_new_page),
        .i_status       (out_status),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input t_action act, input logic [ADDR_W-1:0] addr);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                in_valid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid = 1'b1;
        in_action = act;
        in_addr = addr;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic set_region_base(input logic [PDATA_W-1:0] value);
        cur_base = value[ADDR_W-1:0];
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = REGION_BASE_ADDR;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] slot_addr(input int page, input int slot,
                                                    input int low);
        return cur_base + (ADDR_W'(page) << PAGE_SHIFT) + (ADDR_W'(slot) << SLOT_SHIFT)
               + ADDR_W'(low);
    endfunction

    task automatic run_phase(input int n, input int alloc_pct);
        int kind;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                send_item(ACT_ALLOC, rand_addr());
            end else begin
                kind = $urandom_range(0, 9);
                if (kind < 8) begin
                    send_item(ACT_FREE, slot_addr($urandom_range(0, MAX_PAGES - 1),
                                                  $urandom_range(0, SLOTS - 1),
                                                  $urandom_range(0, 511)));
                end else if (kind == 8) begin
                    send_item(ACT_FREE, slot_addr($urandom_range(MAX_PAGES, 4095),
                                                  $urandom_range(0, SLOTS - 1), 0));
                end else begin
                    send_item(ACT_FREE, rand_addr());
                end
            end
        end
    endtask

    // receiver: changing stall modes, plus a long hold-off now and then
    initial begin
        int cyc;
        int mode;
        int mode_left;
        cyc = 0;
        mode = 0;
        mode_left = 0;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            cyc++;
            if (cyc % 4000 == 2000) begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                cyc += HOLD_CYCLES - 1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: begin
                        out_ready = 1'b1;
                    end
                    1: begin
                        out_ready = 1'($urandom_range(0, 1));
                    end
                    default: begin
                        out_ready = ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    initial begin
        #5_000_000;
        $display("[thread_local_slot_allocator_top] ERROR");
        $finish;
    end

    initial begin
        logic [ADDR_W-1:0] b;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_action = ACT_ALLOC;
        in_addr = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        burst_left = 0;
        cur_base = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: base at the top of the address space so page 1 wraps to 0
        set_region_base(PDATA_W'(TOP_ALIGNED_BASE));
        b = TOP_ALIGNED_BASE;
        send_item(ACT_FREE, '0);
        send_item(ACT_FREE, ALL_ONES_ADDR);
        send_item(ACT_ALLOC, '0);
        send_item(ACT_ALLOC, ALL_ONES_ADDR);
        send_item(ACT_FREE, b + 48'h3FF);
        send_item(ACT_FREE, b + 48'h200);
        send_item(ACT_ALLOC, '0);
        send_item(ACT_FREE, ALL_ONES_ADDR);
        repeat (6) send_item(ACT_ALLOC, rand_addr());
        send_item(ACT_ALLOC, '0);
        send_item(ACT_FREE, 48'h0000_0000_0100);
        send_item(ACT_FREE, 48'h0000_0000_1000);
        send_item(ACT_FREE, 48'h7FFF_FFFF_FFFF);
        send_item(ACT_ALLOC, '0);
        send_item(ACT_FREE, b + 48'h600);
        send_item(ACT_ALLOC, '0);
        send_item(ACT_ALLOC, ALL_ONES_ADDR);
        drain();

        // random: first phase is allocate-heavy to run out of pages
        set_region_base('0);
        run_phase(PHASE_ITEMS, 85);
        drain();
        set_region_base(PDATA_W'(rand_addr() & ~ADDR_W'(12'hFFF)));
        run_phase(PHASE_ITEMS, 50);
        drain();
        set_region_base(PDATA_W'(ALL_ONES_ADDR));
        run_phase(PHASE_ITEMS, 30);
        drain();
        set_region_base({$urandom(), $urandom()});
        run_phase(PHASE_ITEMS, 60);
        drain();
        set_region_base(PDATA_W'(TOP_ALIGNED_BASE));
        run_phase(PHASE_ITEMS, 50);
        drain();

        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[thread_local_slot_allocator_top] OK");
        end else begin
            $display("[thread_local_slot_allocator_top] ERROR");
        end
        $finish;
    end

endmodule
